[rtl/rgbf_pkg.sv]
// Shared types, codes and helper functions for the RGB fade controller.
// No dependencies; used by rgbf_ctrl, rgbf_width and the top level.
`default_nettype none

package rgbf_pkg;

  localparam logic [7:0]  LVL_HIGH  = 8'd254;
  localparam logic [7:0]  LVL_LOW   = 8'd1;
  localparam logic [7:0]  LVL_MAX   = 8'd255;
  localparam logic [7:0]  LVL_MID   = 8'd128;

  localparam logic [15:0] PERIOD_RESET = 16'd14203;
  localparam logic [7:0]  LIMIT_RESET  = 8'd60;

  // Configuration register indexes.
  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  // Operating modes as shown on mode_now.
  localparam logic [1:0] MODE_AUTO  = 2'd0;
  localparam logic [1:0] MODE_RED   = 2'd1;
  localparam logic [1:0] MODE_BLUE  = 2'd2;
  localparam logic [1:0] MODE_GREEN = 2'd3;

  // Channel enable bits.
  localparam logic [2:0] EN_R = 3'b001;
  localparam logic [2:0] EN_G = 3'b010;
  localparam logic [2:0] EN_B = 3'b100;

  // Width = level * period / 1000. The product fits in 24 bits; dropping the
  // low three bits leaves a 21-bit value to divide by 125. With
  // M = ceil(2^28 / 125) the quotient (x * M) >> 28 is exact for x < 2^21.
  localparam int          PROD_W      = 24;
  localparam int          DIV_IN_W    = PROD_W - 3;
  localparam logic [21:0] RECIP_MUL   = 22'd2147484;
  localparam int          RECIP_SHIFT = 28;
  localparam int          WIDTH_W     = 15;

  typedef enum logic [2:0] {
    DEB_IDLE  = 3'b001,
    DEB_PRESS = 3'b010,
    DEB_HELD  = 3'b100
  } deb_t;

  typedef enum logic [2:0] {
    PH_RED   = 3'b001,
    PH_GREEN = 3'b010,
    PH_BLUE  = 3'b100
  } phase_t;

  typedef struct packed {
    deb_t state;
    logic pressed;
  } deb_res_t;

  typedef struct packed {
    logic [7:0] down;
    logic [7:0] up;
    logic       done;
  } fade_res_t;

  // Everything a result carries besides the widths.
  typedef struct packed {
    logic [2:0] en;
    logic [1:0] mode;
    logic [7:0] step;
    logic [7:0] level;
  } res_meta_t;

  // Controller state as seen by the width pipeline.
  typedef struct packed {
    logic [7:0] shown_r;
    logic [7:0] shown_g;
    logic [7:0] shown_b;
    res_meta_t  meta;
  } ctrl_view_t;

  // One debounce sample; pin is active low. An unused code acts as idle.
  function automatic deb_res_t debounce_step(deb_t st, logic pin);
    deb_res_t r;
    r.pressed = 1'b0;
    case (st)
      DEB_PRESS: begin
        if (!pin) begin
          r.state   = DEB_HELD;
          r.pressed = 1'b1;
        end else begin
          r.state = DEB_IDLE;
        end
      end
      DEB_HELD: begin
        if (!pin) begin
          r.state   = DEB_HELD;
          r.pressed = 1'b1;
        end else begin
          r.state = DEB_IDLE;
        end
      end
      default: begin
        r.state = pin ? DEB_IDLE : DEB_PRESS;
      end
    endcase
    return r;
  endfunction

  // One crossfade step: down falls toward LVL_LOW, up rises toward LVL_HIGH.
  function automatic fade_res_t fade_step(logic [7:0] d, logic [7:0] u, logic [7:0] s);
    fade_res_t  r;
    logic [7:0] diff;
    logic [8:0] sum;
    diff = d - s;
    sum  = {1'b0, u} + {1'b0, s};
    r.down = (d > s && diff > LVL_LOW) ? diff : LVL_LOW;
    r.up   = (sum < {1'b0, LVL_HIGH}) ? sum[7:0] : LVL_HIGH;
    r.done = (r.down == LVL_LOW);
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/rgb_fade_two_button_controller_top.sv]
// Two-button RGB fade controller, top level. Depends on rgbf_pkg, rgbf_ctrl, rgbf_width.
// A request passes through the controller state (loaded at the accept edge), then the
// product register, then the width register.
// Throughput: one request per cycle while in_stall is low; the output register lets
// a new request in while a finished result waits. Stall on the input follows output
// stall only once all three stages are full.
// Reset (rst, synchronous) empties the pipeline and restores config and control state.
`default_nettype none

module rgb_fade_two_button_controller_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          action,
  input  wire logic                          sw1_level,
  input  wire logic                          sw2_level,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [rgbf_pkg::WIDTH_W-1:0]  red_width,
  output logic      [rgbf_pkg::WIDTH_W-1:0]  green_width,
  output logic      [rgbf_pkg::WIDTH_W-1:0]  blue_width,
  output logic                               red_on,
  output logic                               green_on,
  output logic                               blue_on,
  output logic      [1:0]                    mode_now,
  output logic      [7:0]                    step_now,
  output logic      [7:0]                    level_now,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import rgbf_pkg::*;

  logic       [15:0] pwm_period;
  logic       [7:0]  long_press_limit;
  logic              in_fire;
  logic              ctrl_valid, prod_valid;
  logic              prod_load, out_load;
  ctrl_view_t        view;
  res_meta_t         prod_meta, out_meta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period       <= PERIOD_RESET;
      long_press_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PERIOD: pwm_period       <= cfg_data;
        CFG_LIMIT:  long_press_limit <= cfg_data[7:0];
        default:    ;
      endcase
    end
  end

  // Pipeline control: each stage moves when the one after it has room.
  assign out_load  = prod_valid && (!out_valid || !out_stall);
  assign prod_load = ctrl_valid && (!prod_valid || out_load);
  assign in_stall  = ctrl_valid && !prod_load;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_valid <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      ctrl_valid <= in_fire || (ctrl_valid && !prod_load);
      prod_valid <= prod_load || (prod_valid && !out_load);
      out_valid  <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (prod_load) prod_meta <= view.meta;
    if (out_load)  out_meta  <= prod_meta;
  end

  rgbf_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .fire             (in_fire),
    .action           (action),
    .sw1_level        (sw1_level),
    .sw2_level        (sw2_level),
    .long_press_limit (long_press_limit),
    .view             (view)
  );

  rgbf_width u_width_r (
    .clk        (clk),
    .prod_load  (prod_load),
    .width_load (out_load),
    .level      (view.shown_r),
    .period     (pwm_period),
    .width      (red_width)
  );

  rgbf_width u_width_g (
    .clk        (clk),
    .prod_load  (prod_load),
    .width_load (out_load),
    .level      (view.shown_g),
    .period     (pwm_period),
    .width      (green_width)
  );

  rgbf_width u_width_b (
    .clk        (clk),
    .prod_load  (prod_load),
    .width_load (out_load),
    .level      (view.shown_b),
    .period     (pwm_period),
    .width      (blue_width)
  );

  assign red_on    = out_meta.en[0];
  assign green_on  = out_meta.en[1];
  assign blue_on   = out_meta.en[2];
  assign mode_now  = out_meta.mode;
  assign step_now  = out_meta.step;
  assign level_now = out_meta.level;

  // The crossfade always keeps exactly two channels lit.
  a_auto_two_on: assert property (@(posedge clk) disable iff (rst)
    (view.meta.mode == MODE_AUTO) |-> ($countones(view.meta.en) == 2))
    else $error("auto fade does not have two channels enabled");

  // The manual level never drops below its floor.
  a_level_floor: assert property (@(posedge clk) disable iff (rst)
    view.meta.level != 8'd0)
    else $error("manual level reached zero");

  // A waiting controller result keeps its state until it moves on.
  a_ctrl_hold: assert property (@(posedge clk) disable iff (rst)
    (ctrl_valid && !prod_load) |=> (ctrl_valid && $stable(view)))
    else $error("controller state changed while its result was held");

  // An accepted request always occupies the first stage next cycle.
  a_fire_fills: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> ctrl_valid)
    else $error("accepted request was lost");

endmodule

`default_nettype wire

[rtl/rgbf_ctrl.sv]
// Button debounce, step/level adjustment, mode selection and crossfade state.
// Depends on rgbf_pkg. State changes only on an accepted request.
`default_nettype none

module rgbf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic               action,
  input  wire logic               sw1_level,
  input  wire logic               sw2_level,
  input  wire logic [7:0]         long_press_limit,
  output rgbf_pkg::ctrl_view_t    view
);
  import rgbf_pkg::*;

  deb_t       sw1_deb, sw1_deb_next;
  deb_t       sw2_deb, sw2_deb_next;
  logic [7:0] step, step_next;
  logic [7:0] level, level_next;
  logic [7:0] hold1, hold1_next;
  logic [7:0] hold2, hold2_next;
  logic       long_held, long_held_next;
  logic [7:0] rel_count, rel_count_next;
  logic [1:0] mode, mode_next;
  phase_t     phase, phase_next;
  logic [7:0] fade_r, fade_r_next, fade_g, fade_g_next, fade_b, fade_b_next;
  logic [7:0] shown_r, shown_r_next, shown_g, shown_g_next, shown_b, shown_b_next;
  logic [2:0] en, en_next;

  deb_res_t   d1, d2;
  fade_res_t  fr;

  always_comb begin
    d1 = debounce_step(sw1_deb, sw1_level);
    d2 = debounce_step(sw2_deb, sw2_level);
    fr = '0;

    sw1_deb_next   = sw1_deb;
    sw2_deb_next   = sw2_deb;
    step_next      = step;
    level_next     = level;
    hold1_next     = hold1;
    hold2_next     = hold2;
    long_held_next = long_held;
    rel_count_next = rel_count;
    mode_next      = mode;
    phase_next     = phase;
    fade_r_next    = fade_r;
    fade_g_next    = fade_g;
    fade_b_next    = fade_b;
    shown_r_next   = shown_r;
    shown_g_next   = shown_g;
    shown_b_next   = shown_b;
    en_next        = en;

    if (fire && !action) begin
      // Button 1: raise step or level, time clicks against a button-2 long press.
      sw1_deb_next = d1.state;
      if (d1.pressed) begin
        if (mode == MODE_AUTO) begin
          if (step < LVL_MAX) step_next = step + 8'd1;
        end else begin
          if (level < LVL_MAX) level_next = level + 8'd1;
        end
        if (long_held) begin
          if (hold1 < long_press_limit) begin
            hold1_next = hold1 + 8'd1;
          end else begin
            mode_next      = MODE_GREEN;
            level_next     = LVL_MID;
            rel_count_next = 8'd0;
          end
        end
      end else begin
        if (long_held && hold1 < long_press_limit && hold1 != 8'd0) begin
          rel_count_next = rel_count + 8'd1;
          mode_next      = (rel_count == 8'd0) ? MODE_RED : MODE_BLUE;
          level_next     = LVL_MID;
        end
        if (!long_held) rel_count_next = 8'd0;
        hold1_next = 8'd0;
      end

      // Button 2 sees the mode and level that button 1 left behind.
      sw2_deb_next = d2.state;
      if (d2.pressed) begin
        if (mode_next == MODE_AUTO) begin
          if (step_next != 8'd0) step_next = step_next - 8'd1;
        end else begin
          if (level_next > LVL_LOW) level_next = level_next - 8'd1;
        end
        if (hold2 < long_press_limit) hold2_next = hold2 + 8'd1;
        else long_held_next = 1'b1;
      end else begin
        hold2_next     = 8'd0;
        long_held_next = 1'b0;
      end
    end else if (fire) begin
      case (mode)
        MODE_AUTO: begin
          case (phase)
            PH_RED: begin
              fr = fade_step(fade_r, fade_g, step);
              fade_r_next = fr.down;
              if (fr.done) begin
                phase_next   = PH_GREEN;
                fade_g_next  = LVL_HIGH;
                fade_b_next  = LVL_LOW;
                en_next      = (en & ~EN_R) | EN_B;
                shown_g_next = LVL_HIGH;
              end else begin
                fade_g_next  = fr.up;
                shown_r_next = fr.down;
                shown_g_next = fr.up;
              end
            end
            PH_GREEN: begin
              fr = fade_step(fade_g, fade_b, step);
              fade_g_next = fr.down;
              if (fr.done) begin
                phase_next   = PH_BLUE;
                fade_b_next  = LVL_HIGH;
                fade_r_next  = LVL_LOW;
                en_next      = (en & ~EN_G) | EN_R;
                shown_b_next = LVL_HIGH;
              end else begin
                fade_b_next  = fr.up;
                shown_g_next = fr.down;
                shown_b_next = fr.up;
              end
            end
            default: begin
              fr = fade_step(fade_b, fade_r, step);
              fade_b_next = fr.down;
              if (fr.done) begin
                phase_next   = PH_RED;
                fade_r_next  = LVL_HIGH;
                fade_g_next  = LVL_LOW;
                en_next      = (en & ~EN_B) | EN_G;
                shown_r_next = LVL_HIGH;
              end else begin
                fade_r_next  = fr.up;
                shown_b_next = fr.down;
                shown_r_next = fr.up;
              end
            end
          endcase
        end
        MODE_RED: begin
          en_next      = EN_R;
          shown_r_next = level;
        end
        MODE_BLUE: begin
          en_next      = EN_B;
          shown_b_next = level;
        end
        default: begin
          en_next      = EN_G;
          shown_g_next = level;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw1_deb   <= DEB_IDLE;
      sw2_deb   <= DEB_IDLE;
      step      <= 8'd1;
      level     <= LVL_MID;
      hold1     <= 8'd0;
      hold2     <= 8'd0;
      long_held <= 1'b0;
      rel_count <= 8'd0;
      mode      <= MODE_AUTO;
      phase     <= PH_RED;
      fade_r    <= LVL_HIGH;
      fade_g    <= LVL_LOW;
      fade_b    <= LVL_LOW;
      shown_r   <= LVL_HIGH;
      shown_g   <= LVL_LOW;
      shown_b   <= LVL_LOW;
      en        <= EN_R | EN_G;
    end else begin
      sw1_deb   <= sw1_deb_next;
      sw2_deb   <= sw2_deb_next;
      step      <= step_next;
      level     <= level_next;
      hold1     <= hold1_next;
      hold2     <= hold2_next;
      long_held <= long_held_next;
      rel_count <= rel_count_next;
      mode      <= mode_next;
      phase     <= phase_next;
      fade_r    <= fade_r_next;
      fade_g    <= fade_g_next;
      fade_b    <= fade_b_next;
      shown_r   <= shown_r_next;
      shown_g   <= shown_g_next;
      shown_b   <= shown_b_next;
      en        <= en_next;
    end
  end

  assign view.shown_r    = shown_r;
  assign view.shown_g    = shown_g;
  assign view.shown_b    = shown_b;
  assign view.meta.en    = en;
  assign view.meta.mode  = mode;
  assign view.meta.step  = step;
  assign view.meta.level = level;

endmodule

`default_nettype wire

[rtl/rgbf_width.sv]
// Two-stage scaler for one channel: level * period, then divide by 1000.
// Depends on rgbf_pkg for the reciprocal constants.
`default_nettype none

module rgbf_width (
  input  wire logic                         clk,
  input  wire logic                         prod_load,
  input  wire logic                         width_load,
  input  wire logic [7:0]                   level,
  input  wire logic [15:0]                  period,
  output logic      [rgbf_pkg::WIDTH_W-1:0] width
);
  import rgbf_pkg::*;

  localparam int QUOT_W = DIV_IN_W + $bits(RECIP_MUL);

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] scaled;

  // Dividing by 8 first is exact for the floor, so only /125 remains.
  assign scaled = QUOT_W'(prod[PROD_W-1:3]) * QUOT_W'(RECIP_MUL);

  always_ff @(posedge clk) begin
    if (prod_load) begin
      prod <= PROD_W'(level) * PROD_W'(period);
    end
    if (width_load) begin
      width <= scaled[RECIP_SHIFT +: WIDTH_W];
    end
  end

endmodule

`default_nettype wire
